[hdl/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and codes for the streaming find-and-replace-all block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  typedef enum logic [2:0] {
    OP_BEGIN = 3'd0,
    OP_PAT   = 3'd1,
    OP_REP   = 3'd2,
    OP_TEXT  = 3'd3,
    OP_END   = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PAT_K0,
    S_PAT_RD,
    S_PAT_CMP,
    S_TXT_CMP,
    S_PUSH_C,
    S_PF_RD,
    S_PF_WR,
    S_RP_RD,
    S_RP_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic clear_job;
    logic set_ovf;
    logic pat_first;
    logic pat_store;
    logic fail_write;
    logic rd_k0;
    logic load_k;
    logic rd_k;
    logic step_k;
    logic rep_write;
    logic rd_j;
    logic fall_start;
    logic end_start;
    logic rep_start;
    logic rd_pat_e;
    logic rd_rep_e;
    logic push_c;
    logic push_pat;
    logic push_rep;
    logic j_inc;
    logic j_clear;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       plen_zero;
    logic       plen_full;
    logic       rlen_zero;
    logic       rlen_full;
    logic       j_zero;
    logic       k_zero;
    logic       pat_eq_c;
    logic       j_last;
    logic       e_last_pat;
    logic       e_last_rep;
    logic       can_push;
    logic       slot_free;
  } stat_t;

endpackage

`default_nettype wire

[hdl/sfr_if.sv]
// ----------------------------------------------------------------------------
// sfr_if
// Valid/ready channels for operation items and rewritten text results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] data_byte;

  modport source(output valid, output operation, output data_byte, input ready);
  modport sink(input valid, input operation, input data_byte, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_of_run;
  logic       end_of_text;
  logic       load_overflow;

  modport source(output valid, output out_byte, output byte_valid, output last_of_run,
                 output end_of_text, output load_overflow, input ready);
  modport sink(input valid, input out_byte, input byte_valid, input last_of_run,
               input end_of_text, input load_overflow, output ready);
endinterface

`default_nettype wire

[hdl/sfr_dp.sv]
// ----------------------------------------------------------------------------
// sfr_dp
// Datapath: pattern, replacement and failure memories, match counters,
// one-deep hold stage and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_dp import sfr_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_data_byte,
  input  cmd_t       cmd,
  output stat_t      stat,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       last_of_run,
  output logic       end_of_text,
  output logic       load_overflow
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);

  logic [7:0]    pat_mem  [MAX_LEN];
  logic [7:0]    rep_mem  [MAX_LEN];
  logic [AW-1:0] fail_mem [MAX_LEN];

  logic [2:0]    op;
  logic [7:0]    c;
  logic          ovf;
  logic [LW-1:0] plen;
  logic [LW-1:0] rlen;
  logic [AW-1:0] j;
  logic [AW-1:0] k;
  logic [LW-1:0] cnt;
  logic [LW-1:0] e;
  logic [7:0]    pat_q;
  logic [7:0]    rep_q;
  logic [AW-1:0] fail_q;
  logic          hold_valid;
  logic [7:0]    hold_byte;

  logic          pat_rd;
  logic [AW-1:0] pat_raddr;
  logic          fail_rd;
  logic [AW-1:0] fail_raddr;
  logic          fail_we;
  logic [AW-1:0] fail_wdata;
  logic          push_any;
  logic [7:0]    push_byte;
  logic          slot_free;

  assign pat_rd  = cmd.rd_k | cmd.rd_j | cmd.rd_pat_e;
  assign fail_rd = cmd.rd_k0 | cmd.rd_k | cmd.rd_j;
  assign fail_we = cmd.pat_first | cmd.fail_write;
  assign fail_wdata = cmd.pat_first ? '0 : AW'(k + AW'(pat_q == c));

  always_comb begin
    if (cmd.rd_k) begin
      pat_raddr = k;
    end else if (cmd.rd_pat_e) begin
      pat_raddr = e[AW-1:0];
    end else begin
      pat_raddr = j;
    end
  end

  always_comb begin
    if (cmd.rd_k0) begin
      fail_raddr = plen[AW-1:0] - AW'(1);
    end else if (cmd.rd_k) begin
      fail_raddr = k - AW'(1);
    end else begin
      fail_raddr = j - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pat_first | cmd.pat_store) begin
      pat_mem[plen[AW-1:0]] <= c;
    end
    if (pat_rd) begin
      pat_q <= pat_mem[pat_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fail_we) begin
      fail_mem[plen[AW-1:0]] <= fail_wdata;
    end
    if (fail_rd) begin
      fail_q <= fail_mem[fail_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rep_write) begin
      rep_mem[rlen[AW-1:0]] <= c;
    end
    if (cmd.rd_rep_e) begin
      rep_q <= rep_mem[e[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= '0;
      rlen <= '0;
      j    <= '0;
    end else begin
      if (cmd.clear_job) begin
        plen <= '0;
        rlen <= '0;
        j    <= '0;
      end
      if (cmd.pat_first | cmd.fail_write) begin
        plen <= plen + LW'(1);
      end
      if (cmd.rep_write) begin
        rlen <= rlen + LW'(1);
      end
      if (cmd.fall_start) begin
        j <= fail_q;
      end
      if (cmd.end_start | cmd.j_clear) begin
        j <= '0;
      end
      if (cmd.j_inc) begin
        j <= j + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= in_operation;
      c   <= in_data_byte;
      ovf <= 1'b0;
    end
    if (cmd.set_ovf) begin
      ovf <= 1'b1;
    end
    if (cmd.load_k | cmd.step_k) begin
      k <= fail_q;
    end
    if (cmd.fall_start) begin
      cnt <= LW'(j) - LW'(fail_q);
      e   <= '0;
    end
    if (cmd.end_start) begin
      cnt <= LW'(j);
      e   <= '0;
    end
    if (cmd.rep_start) begin
      e <= '0;
    end
    if (cmd.push_pat | cmd.push_rep) begin
      e <= e + LW'(1);
    end
  end

  assign push_any  = cmd.push_c | cmd.push_pat | cmd.push_rep;
  assign push_byte = cmd.push_c ? c : (cmd.push_pat ? pat_q : rep_q);
  assign slot_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else if (push_any) begin
        if (hold_valid) begin
          out_valid <= 1'b1;
        end else if (out_valid & out_ready) begin
          out_valid <= 1'b0;
        end
        hold_valid <= 1'b1;
      end else if (out_valid & out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_any) begin
      hold_byte <= push_byte;
      if (hold_valid) begin
        out_byte      <= hold_byte;
        byte_valid    <= 1'b1;
        last_of_run   <= 1'b0;
        end_of_text   <= 1'b0;
        load_overflow <= 1'b0;
      end
    end
    if (cmd.finish) begin
      out_byte      <= hold_valid ? hold_byte : 8'd0;
      byte_valid    <= hold_valid;
      last_of_run   <= 1'b1;
      end_of_text   <= (op == OP_END);
      load_overflow <= ovf;
    end
  end

  always_comb begin
    stat.op         = op;
    stat.plen_zero  = (plen == '0);
    stat.plen_full  = (plen >= LW'(MAX_LEN));
    stat.rlen_zero  = (rlen == '0);
    stat.rlen_full  = (rlen >= LW'(MAX_LEN));
    stat.j_zero     = (j == '0);
    stat.k_zero     = (k == '0);
    stat.pat_eq_c   = (pat_q == c);
    stat.j_last     = ((LW'(j) + LW'(1)) == plen);
    stat.e_last_pat = ((e + LW'(1)) == cnt);
    stat.e_last_rep = ((e + LW'(1)) == rlen);
    stat.can_push   = ~hold_valid | slot_free;
    stat.slot_free  = slot_free;
  end

endmodule

`default_nettype wire

[hdl/sfr_ctrl.sv]
// ----------------------------------------------------------------------------
// sfr_ctrl
// Controller: sequences loading, failure-table build, text matching and
// result emission over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_ctrl import sfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_PAT: begin
            if (!stat.plen_full && !stat.plen_zero) begin
              state_next = S_PAT_K0;
            end else begin
              state_next = S_FINISH;
            end
          end
          OP_TEXT: begin
            state_next = stat.plen_zero ? S_PUSH_C : S_TXT_CMP;
          end
          OP_END: begin
            state_next = stat.j_zero ? S_FINISH : S_PF_RD;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_PAT_K0: state_next = S_PAT_RD;
      S_PAT_RD: state_next = S_PAT_CMP;
      S_PAT_CMP: begin
        if (!stat.k_zero && !stat.pat_eq_c) begin
          state_next = S_PAT_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_TXT_CMP: begin
        if (!stat.j_zero && !stat.pat_eq_c) begin
          state_next = S_PF_RD;
        end else if (stat.pat_eq_c) begin
          if (stat.j_last && !stat.rlen_zero) begin
            state_next = S_RP_RD;
          end else begin
            state_next = S_FINISH;
          end
        end else begin
          state_next = S_PUSH_C;
        end
      end
      S_PUSH_C: begin
        if (stat.can_push) begin
          state_next = S_FINISH;
        end
      end
      S_PF_RD: state_next = S_PF_WR;
      S_PF_WR: begin
        if (stat.can_push) begin
          if (!stat.e_last_pat) begin
            state_next = S_PF_RD;
          end else if (stat.op == OP_END) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_TXT_CMP;
          end
        end
      end
      S_RP_RD: state_next = S_RP_WR;
      S_RP_WR: begin
        if (stat.can_push) begin
          state_next = stat.e_last_rep ? S_FINISH : S_RP_RD;
        end
      end
      S_FINISH: begin
        if (stat.slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_BEGIN: cmd.clear_job = 1'b1;
          OP_PAT: begin
            if (stat.plen_full) begin
              cmd.set_ovf = 1'b1;
            end else if (stat.plen_zero) begin
              cmd.pat_first = 1'b1;
            end else begin
              cmd.pat_store = 1'b1;
              cmd.rd_k0     = 1'b1;
            end
          end
          OP_REP: begin
            if (stat.rlen_full) begin
              cmd.set_ovf = 1'b1;
            end else begin
              cmd.rep_write = 1'b1;
            end
          end
          OP_TEXT: cmd.rd_j = ~stat.plen_zero;
          OP_END: cmd.end_start = ~stat.j_zero;
          default: cmd = '0;
        endcase
      end
      S_PAT_K0: cmd.load_k = 1'b1;
      S_PAT_RD: cmd.rd_k = 1'b1;
      S_PAT_CMP: begin
        if (!stat.k_zero && !stat.pat_eq_c) begin
          cmd.step_k = 1'b1;
        end else begin
          cmd.fail_write = 1'b1;
        end
      end
      S_TXT_CMP: begin
        if (!stat.j_zero && !stat.pat_eq_c) begin
          cmd.fall_start = 1'b1;
        end else if (stat.pat_eq_c) begin
          if (stat.j_last) begin
            cmd.j_clear   = 1'b1;
            cmd.rep_start = 1'b1;
          end else begin
            cmd.j_inc = 1'b1;
          end
        end
      end
      S_PUSH_C: cmd.push_c = stat.can_push;
      S_PF_RD: cmd.rd_pat_e = 1'b1;
      S_PF_WR: begin
        if (stat.can_push) begin
          cmd.push_pat = 1'b1;
          cmd.rd_j     = stat.e_last_pat & (stat.op != OP_END);
        end
      end
      S_RP_RD: cmd.rd_rep_e = 1'b1;
      S_RP_WR: cmd.push_rep = stat.can_push;
      S_FINISH: cmd.finish = stat.slot_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/stream_find_replace_all_core.sv]
// ----------------------------------------------------------------------------
// stream_find_replace_all_core
// Streaming find-and-replace-all with a KMP failure table built on load.
//
// text_in carries one operation per transaction: begin job, append pattern
// byte, append replacement byte, text byte, end text. text_out carries the
// results; every transaction in gives one or more results, the last one
// marked last_of_run. One transaction is worked on at a time.
// Per item: a later pattern append walks the failure table one comparison
// at a time; a text byte that breaks a match falls back and releases the
// pattern bytes that can no longer begin one; a completed match emits the
// replacement bytes; end text releases the partial match. Each memory has
// a single read port with a registered read, so each released byte and
// each replacement byte takes a read state and a write state.
// A one-deep hold stage and the output register let work go on while the
// receiver stalls; a stall of more than one result holds the controller.
// Reset empties pattern and replacement and clears any partial match;
// stored bytes stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_replace_all_core import sfr_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic      clk,
  input  logic      rst,
  sfr_in_if.sink    text_in,
  sfr_out_if.source text_out
);

  cmd_t  cmd;
  stat_t stat;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text_in.valid),
    .in_ready (text_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfr_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .in_operation  (text_in.operation),
    .in_data_byte  (text_in.data_byte),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (text_out.valid),
    .out_ready     (text_out.ready),
    .out_byte      (text_out.out_byte),
    .byte_valid    (text_out.byte_valid),
    .last_of_run   (text_out.last_of_run),
    .end_of_text   (text_out.end_of_text),
    .load_overflow (text_out.load_overflow)
  );

endmodule

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for stream_find_replace_all_core. Directed jobs cover an empty
// pattern, matches and partial-match release, deletion by an empty
// replacement, pattern growth during text, store overflow, spare operation
// codes and the largest replacement burst. Randomised jobs follow, over a
// two-symbol alphabet with occasional noise. A local predictor rewrites each
// accepted transaction and a checker compares every result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import sfr_pkg::*;

  localparam int MAX_LEN = 64;
  localparam int AW = $clog2(MAX_LEN);
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS = 12;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST = 3'd7;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       end_of_text;
    logic       load_overflow;
  } rewrite_t;

  logic clk = 1'b0;
  logic rst;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  stream_find_replace_all_core #(.MAX_LEN(MAX_LEN)) dut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (in_ch),
    .text_out (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0] pat_mem [MAX_LEN];
  logic [7:0] rep_mem [MAX_LEN];
  logic [6:0] fail_mem [MAX_LEN];
  logic [6:0] pat_len;
  logic [6:0] rep_len;
  logic [6:0] match_len;

  rewrite_t rewrite_q [$];
  rewrite_t run_q [$];

  int  n_errors = 0;
  int  n_counted = 0;
  int  n_cycles = 0;
  int  stall_left = 0;
  bit  idle_en = 1'b1;

  function automatic void emit_byte(input logic [7:0] b);
    rewrite_t r;
    r = '0;
    r.out_byte = b;
    r.byte_valid = 1'b1;
    run_q = {run_q, r};
  endfunction

  function automatic void emit_prefix(input logic [6:0] count);
    for (int i = 0; i < count && i < MAX_LEN; i++) emit_byte(pat_mem[AW'(i)]);
  endfunction

  function automatic void grow_pattern(input logic [7:0] c);
    logic [6:0] k;
    pat_mem[AW'(pat_len)] = c;
    if (pat_len == 0) begin
      fail_mem[0] = '0;
    end else begin
      k = fail_mem[AW'(pat_len - 7'd1)];
      while (k > 0 && pat_mem[AW'(k)] != c) k = fail_mem[AW'(k - 7'd1)];
      if (pat_mem[AW'(k)] == c) k++;
      fail_mem[AW'(pat_len)] = k;
    end
    pat_len++;
  endfunction

  function automatic void scan_text(input logic [7:0] c);
    logic [6:0] j;
    logic [6:0] f;
    j = match_len;
    if (pat_len == 0) begin
      emit_byte(c);
      return;
    end
    // release bytes that can no longer begin a match
    while (j > 0 && j < pat_len && pat_mem[AW'(j)] != c) begin
      f = fail_mem[AW'(j - 7'd1)];
      emit_prefix(j - f);
      j = f;
    end
    if (j < pat_len && pat_mem[AW'(j)] == c) begin
      j++;
      if (j == pat_len) begin
        for (int i = 0; i < rep_len; i++) emit_byte(rep_mem[AW'(i)]);
        j = '0;
      end
    end else begin
      emit_byte(c);
    end
    match_len = j;
  endfunction

  function automatic void predict_rewrite(input logic [2:0] op, input logic [7:0] b);
    rewrite_t r;
    logic ovf;
    logic eot;
    ovf = 1'b0;
    eot = 1'b0;
    run_q.delete();
    case (op)
      OP_BEGIN: begin
        pat_len = '0;
        rep_len = '0;
        match_len = '0;
      end
      OP_PAT: begin
        if (pat_len >= MAX_LEN) ovf = 1'b1;
        else grow_pattern(b);
      end
      OP_REP: begin
        if (rep_len >= MAX_LEN) begin
          ovf = 1'b1;
        end else begin
          rep_mem[AW'(rep_len)] = b;
          rep_len++;
        end
      end
      OP_TEXT: scan_text(b);
      OP_END: begin
        emit_prefix(match_len);
        match_len = '0;
        eot = 1'b1;
      end
      default: ;
    endcase
    if (run_q.size() == 0) begin
      r = '0;
      r.load_overflow = ovf;
      run_q = {run_q, r};
    end
    run_q[run_q.size() - 1].last_of_run = 1'b1;
    run_q[run_q.size() - 1].end_of_text = eot;
    foreach (run_q[i]) rewrite_q = {rewrite_q, run_q[i]};
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    rewrite_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (rewrite_q.size() == 0) begin
        $error("unexpected result: out_byte 0x%0h", out_ch.out_byte);
        n_errors++;
      end else begin
        want = rewrite_q.pop_front();
        check_field("out_byte", int'(want.out_byte), int'(out_ch.out_byte));
        check_field("byte_valid", int'(want.byte_valid), int'(out_ch.byte_valid));
        check_field("last_of_run", int'(want.last_of_run), int'(out_ch.last_of_run));
        check_field("end_of_text", int'(want.end_of_text), int'(out_ch.end_of_text));
        check_field("load_overflow", int'(want.load_overflow),
                    int'(out_ch.load_overflow));
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(7) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(18, 1) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input logic [2:0] op, input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (idle_en && $urandom_range(5) == 0) begin
      gap = $urandom_range(18, 1);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    predict_rewrite(op, b);
    if (op <= OP_END) n_counted++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (rewrite_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_pattern();
    send_item(OP_BEGIN, 8'h00);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_TEXT, 8'hFF);
    send_item(OP_REP, 8'hA5);
    send_item(OP_TEXT, 8'h5A);
    send_item(OP_END, 8'hFF);
    for (int code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++)
      send_item(code[2:0], 8'($urandom));
  endtask

  task automatic test_basic_replace();
    string txt;
    txt = "aababa";
    send_item(OP_BEGIN, 8'h00);
    send_item(OP_PAT, "a");
    send_item(OP_PAT, "b");
    send_item(OP_REP, "X");
    send_item(OP_REP, "Y");
    send_item(OP_REP, "Z");
    foreach (txt[i]) send_item(OP_TEXT, txt[i]);
    send_item(OP_END, 8'h00);
    send_item(OP_TEXT, "b");
    send_item(OP_END, 8'h00);
  endtask

  task automatic test_empty_replacement();
    send_item(OP_BEGIN, 8'h00);
    send_item(OP_PAT, "a");
    send_item(OP_PAT, "a");
    repeat (3) send_item(OP_TEXT, "a");
    send_item(OP_END, 8'h00);
    send_item(OP_TEXT, "a");
    send_item(OP_BEGIN, 8'h00);
  endtask

  task automatic test_pattern_mid_text();
    send_item(OP_BEGIN, 8'h00);
    send_item(OP_PAT, "a");
    send_item(OP_PAT, "b");
    send_item(OP_REP, "Q");
    send_item(OP_TEXT, "a");
    send_item(OP_PAT, "c");
    send_item(OP_TEXT, "b");
    send_item(OP_TEXT, "c");
    send_item(OP_TEXT, "a");
    send_item(OP_TEXT, "b");
    send_item(OP_TEXT, "d");
    send_item(OP_END, 8'h00);
  endtask

  task automatic test_overflow();
    send_item(OP_BEGIN, 8'h00);
    for (int i = 0; i < MAX_LEN; i++) send_item(OP_PAT, (i == MAX_LEN - 1) ? "b" : "a");
    send_item(OP_PAT, "a");
    repeat (2) send_item(OP_TEXT, "a");
    send_item(OP_END, 8'h00);
    send_item(OP_BEGIN, 8'h00);
    send_item(OP_PAT, "a");
    for (int i = 0; i < MAX_LEN; i++) send_item(OP_REP, 8'($urandom));
    send_item(OP_REP, 8'($urandom));
    send_item(OP_TEXT, "a");
    send_item(OP_TEXT, "b");
    send_item(OP_END, 8'h00);
  endtask

  task automatic run_random_job();
    logic [7:0] sym [2];
    int n_pat;
    int n_rep;
    int n_text;
    int pick;
    sym[0] = 8'($urandom);
    sym[1] = sym[0] ^ (8'h01 << $urandom_range(7));
    send_item(OP_BEGIN, 8'($urandom));
    n_pat = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
    repeat (n_pat) send_item(OP_PAT, sym[1'($urandom_range(1))]);
    n_rep = $urandom_range(4);
    repeat (n_rep) send_item(OP_REP, 8'($urandom));
    n_text = $urandom_range(24, 8);
    repeat (n_text) begin
      pick = $urandom_range(19);
      if (pick == 0) send_item(OP_PAT, sym[1'($urandom_range(1))]);
      else if (pick == 1)
        send_item(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), 8'($urandom));
      else if (pick == 2) send_item(OP_TEXT, 8'($urandom));
      else send_item(OP_TEXT, sym[1'($urandom_range(1))]);
    end
    // drop the end now and then so the next begin discards a partial match
    if ($urandom_range(7) != 0) send_item(OP_END, 8'($urandom));
  endtask

  task automatic test_random();
    int start;
    start = n_counted;
    while (n_counted - start < RANDOM_ITEMS) run_random_job();
    idle_en = 1'b0;
    run_random_job();
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_BEGIN;
    in_ch.data_byte = 8'h00;
    out_ch.ready = 1'b0;
    pat_len = '0;
    rep_len = '0;
    match_len = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_pattern();
    test_basic_replace();
    wait_drained();
    test_empty_replacement();
    test_pattern_mid_text();
    test_overflow();
    test_random();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
